[hw/rtl/breakpoint_address_table_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the breakpoint address table.
// ---------------------------------------------------------------------------
`ifndef BREAKPOINT_ADDRESS_TABLE_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define BPT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define BPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bpt_pkg.sv]
// ---------------------------------------------------------------------------
// bpt_pkg
// Types and constants shared by the breakpoint address table modules.
// ---------------------------------------------------------------------------
package bpt_pkg;

    localparam int SLOTS  = 8;
    localparam int ADDR_W = 32;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
    } bpt_req_t;

    typedef struct packed {
        logic hit;
        logic add_failed;
        logic enabled;
    } bpt_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic finish;
    } bpt_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_remove;
        logic scan_last;
    } bpt_sts_t;

endpackage

[hw/rtl/bpt_ctrl.sv]
// ---------------------------------------------------------------------------
// bpt_ctrl
// Sequencer for the breakpoint table: one execute step for check, add and the
// unused command; the execute step, a slot-by-slot walk and a finish step for remove.
// ---------------------------------------------------------------------------
`include "breakpoint_address_table_macros.svh"

module bpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpt_pkg::bpt_sts_t sts,
    output bpt_pkg::bpt_ctl_t ctl
);
    import bpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.is_remove ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ST_EXEC:
            begin
                ctl.exec = !sts.is_remove;
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `BPT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy && state_reg == ST_EXEC,
                     "accepted transfer did not enter the execute step")
    `BPT_ASSERT_NEXT(a_finish_returns_idle, state_reg == ST_FINISH, !busy,
                     "remove finish step did not return to idle")

endmodule

[hw/rtl/bpt_datapath.sv]
// ---------------------------------------------------------------------------
// bpt_datapath
// Slot registers, enabled flag, scan index and result register of the
// breakpoint table.
// ---------------------------------------------------------------------------
`include "breakpoint_address_table_macros.svh"

module bpt_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bpt_pkg::bpt_req_t request,
    input  bpt_pkg::bpt_ctl_t ctl,
    output bpt_pkg::bpt_sts_t sts,
    output logic              result_valid,
    output bpt_pkg::bpt_rsp_t result
);
    import bpt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [ADDR_W-1:0] slot_reg  [SLOTS];
    logic [ADDR_W-1:0] slot_next [SLOTS];
    logic              enabled_reg;
    logic              enabled_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [1:0]        cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              result_valid_reg;
    bpt_rsp_t          result_reg;
    bpt_rsp_t          result_next;

    logic              any_match;
    logic              any_empty;
    logic              any_nonzero;
    logic              any_nonzero_next;
    logic [IDX_W-1:0]  first_empty;
    logic              scan_match;

    // Parallel compares over all slots.
    always_comb
    begin
        any_match        = 1'b0;
        any_empty        = 1'b0;
        any_nonzero      = 1'b0;
        any_nonzero_next = 1'b0;
        first_empty      = '0;
        for (int j = SLOTS - 1; j >= 0; j--)
        begin
            if (slot_reg[j] == addr_reg)
            begin
                any_match = 1'b1;
            end
            if (slot_reg[j] == '0)
            begin
                any_empty   = 1'b1;
                first_empty = IDX_W'(j);
            end
            else
            begin
                any_nonzero = 1'b1;
            end
        end
        any_nonzero_next = any_nonzero;
    end

    assign scan_match = (slot_reg[idx_reg] == addr_reg);
    assign sts        = '{is_remove: (cmd_reg == CMD_REMOVE),
                          scan_last: (idx_reg == LAST_IDX)};

    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            slot_next[j] = slot_reg[j];
        end
        enabled_next = enabled_reg;
        idx_next     = idx_reg;
        result_next  = result_reg;

        if (ctl.load)
        begin
            idx_next = '0;
        end

        if (ctl.exec)
        begin
            result_next = '0;
            case (cmd_reg)
                CMD_CHECK:
                begin
                    result_next.hit = any_match;
                end
                CMD_ADD:
                begin
                    if (any_empty)
                    begin
                        slot_next[first_empty] = addr_reg;
                        enabled_next           = 1'b1;
                    end
                    else
                    begin
                        result_next.add_failed = 1'b1;
                    end
                end
                default:
                begin
                    result_next.hit = 1'b0;
                end
            endcase
            result_next.enabled = enabled_next;
        end

        // A match pulls every later slot down one place and clears the last
        // slot; the walk then moves on, so the entry that slid into this
        // slot is not compared again.
        if (ctl.scan_step)
        begin
            if (scan_match)
            begin
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (j >= int'(idx_reg))
                    begin
                        slot_next[j] = (j == SLOTS - 1) ? '0 : slot_reg[(j + 1) % SLOTS];
                    end
                end
            end
            idx_next = idx_reg + IDX_W'(1);
        end

        if (ctl.finish)
        begin
            enabled_next        = enabled_reg && any_nonzero_next;
            result_next         = '0;
            result_next.enabled = enabled_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                slot_reg[j] <= '0;
            end
            enabled_reg      <= 1'b0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                slot_reg[j] <= slot_next[j];
            end
            enabled_reg      <= enabled_next;
            idx_reg          <= idx_next;
            result_valid_reg <= ctl.exec || ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= request.cmd;
            addr_reg <= request.address;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `BPT_ASSERT_SAME(a_flag_clear_means_empty, !enabled_reg, !any_nonzero,
                     "enabled flag is clear while a slot holds an address")
    `BPT_ASSERT_SAME(a_hit_fail_exclusive, result_valid_reg,
                     !(result_reg.hit && result_reg.add_failed),
                     "hit and add failure reported together")
    `BPT_ASSERT_NEXT(a_scan_advances, ctl.scan_step && !sts.scan_last,
                     idx_reg == $past(idx_reg) + IDX_W'(1),
                     "scan index did not advance by one slot")

endmodule

[hw/rtl/breakpoint_address_table.sv]
// ---------------------------------------------------------------------------
// breakpoint_address_table
// Table of breakpoint addresses with check, add and remove commands; an
// address of zero marks an empty slot.
// ---------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  command   start, busy            request (cmd, address)
//  result    result_valid strobe    result (hit, add_failed, enabled)
//
//  Check, add and the unused command pass through the execute step, and the
//  result strobe is registered from it; busy is high during that step.
//  Remove walks the slot registers one slot per cycle from the execute step
//  to the finish step, from which the result strobe is registered.
//  Reset clears every slot and the enabled flag at once; no clearing pass.
//  The result is shown for one cycle only and a new transfer may be
//  accepted in that same cycle.
// ---------------------------------------------------------------------------
module breakpoint_address_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpt_pkg::bpt_req_t request,
    output logic              result_valid,
    output bpt_pkg::bpt_rsp_t result
);
    import bpt_pkg::*;

    bpt_ctl_t ctl;
    bpt_sts_t sts;

    bpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    bpt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[tb/tb_breakpoint_address_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_breakpoint_address_table
// Self-checking bench for the breakpoint address table. A directed sequence
// covers the empty and full table, address zero, the top address, adjacent
// duplicates and the unused command. It is followed by random phases that
// draw addresses from a small pool, so that hits, full adds and removes of
// duplicates are common. Every result is compared with a model of the table
// kept in the bench.
// ---------------------------------------------------------------------------
module tb_breakpoint_address_table;
    import bpt_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_GAP      = 17;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 3);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_MAX     = 12;

    typedef struct {
        bpt_req_t req;
        int       gap;
    } bpt_item_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    bpt_req_t request;
    logic     result_valid;
    bpt_rsp_t result;

    bpt_item_t         cmd_queue[$];
    bpt_rsp_t          expected_rsp[$];
    logic [ADDR_W-1:0] model_slots[SLOTS];
    logic              model_enabled;
    logic              took_cmd;
    bit                no_gaps;
    int                idle_count  = 0;
    int                cycle_count = 0;
    int                failures    = 0;
    int                n_check     = 0;
    int                n_hit       = 0;
    int                n_add       = 0;
    int                n_full      = 0;
    int                n_remove    = 0;
    int                n_nop       = 0;

    breakpoint_address_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Applies one command to the bench copy of the table and returns the
    // response the block should produce for it.
    function automatic bpt_rsp_t table_update(bpt_req_t req);
        bpt_rsp_t rsp;
        bit       any_set;
        rsp     = '0;
        any_set = 1'b0;
        case (req.cmd)
            CMD_CHECK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (model_slots[i] == req.address)
                        rsp.hit = 1'b1;
            end
            CMD_ADD: begin
                rsp.add_failed = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (rsp.add_failed && model_slots[i] == '0)
                    begin
                        model_slots[i] = req.address;
                        model_enabled  = 1'b1;
                        rsp.add_failed = 1'b0;
                    end
                end
            end
            CMD_REMOVE: begin
                // The scan moves on after a shift, so an entry that slid
                // into the current index is not compared again.
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (model_slots[i] == req.address)
                    begin
                        for (int j = i; j < SLOTS - 1; j++)
                            model_slots[j] = model_slots[j + 1];
                        model_slots[SLOTS - 1] = '0;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    if (model_slots[i] != '0)
                        any_set = 1'b1;
                if (!any_set)
                    model_enabled = 1'b0;
            end
            default: ;
        endcase
        rsp.enabled = model_enabled;
        return rsp;
    endfunction

    function automatic int draw_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic queue_cmd(cmd_e_t cmd, logic [ADDR_W-1:0] addr);
        bpt_item_t item;
        item.req.cmd     = cmd;
        item.req.address = addr;
        item.gap         = draw_gap();
        cmd_queue.push_back(item);
    endtask

    // Random phases: each one has its own command mix, address pool and
    // idling style.
    task automatic queue_random_phases();
        logic [ADDR_W-1:0] pool[POOL_MAX];
        int                made;
        int                phase_len;
        int                pool_size;
        int                chk_w;
        int                add_w;
        int                pick;
        logic [ADDR_W-1:0] addr;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(50, 150);
            pool_size = $urandom_range(2, POOL_MAX);
            chk_w     = $urandom_range(20, 60);
            add_w     = $urandom_range(10, 90 - chk_w);
            no_gaps   = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < pool_size; k++)
            begin
                pool[k] = $urandom;
                if ($urandom_range(0, 9) == 0)
                    pool[k] = '0;
                else if ($urandom_range(0, 9) == 0)
                    pool[k] = '1;
            end
            for (int n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    addr = $urandom;
                else
                    addr = pool[$urandom_range(0, pool_size - 1)];
                pick = $urandom_range(0, 99);
                if (pick < chk_w)
                    queue_cmd(CMD_CHECK, addr);
                else if (pick < chk_w + add_w)
                    queue_cmd(CMD_ADD, addr);
                else if (pick < 96)
                    queue_cmd(CMD_REMOVE, addr);
                else
                    queue_cmd(CMD_NOP, addr);
            end
            made += phase_len;
        end
    endtask

    // Driver: presents the next pending command once its idle gap has run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || took_cmd)
            begin
                if (cmd_queue.size() == 0)
                    start <= 1'b0;
                else if (idle_count < cmd_queue[0].gap)
                begin
                    idle_count <= idle_count + 1;
                    start      <= 1'b0;
                end
                else
                begin
                    request    <= cmd_queue[0].req;
                    start      <= 1'b1;
                    idle_count <= 0;
                    void'(cmd_queue.pop_front());
                end
            end
        end
    end

    // Monitor: checks each result strobe, then records a new transfer.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        bpt_rsp_t want;
        if (!rst_n)
            took_cmd <= 1'b0;
        else
        begin
            if (result_valid)
            begin
                if (expected_rsp.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: result with none expected: hit=%b add_failed=%b enabled=%b",
                                 $realtime, result.hit, result.add_failed, result.enabled);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (result.hit !== want.hit || result.add_failed !== want.add_failed ||
                        result.enabled !== want.enabled)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display("%0t: mismatch: expected hit=%b add_failed=%b enabled=%b, got hit=%b add_failed=%b enabled=%b",
                                     $realtime, want.hit, want.add_failed, want.enabled,
                                     result.hit, result.add_failed, result.enabled);
                    end
                end
            end
            took_cmd <= start && !busy;
            if (start && !busy)
            begin
                want = table_update(request);
                expected_rsp.push_back(want);
                case (request.cmd)
                    CMD_CHECK: begin
                        n_check++;
                        n_hit += want.hit;
                    end
                    CMD_ADD: begin
                        n_add++;
                        n_full += want.add_failed;
                    end
                    CMD_REMOVE: n_remove++;
                    default:    n_nop++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        model_enabled = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            model_slots[i] = '0;

        // Directed sequence.
        no_gaps = 1'b0;
        queue_cmd(CMD_CHECK,  32'h0000_0000);   // empty table: address zero hits
        queue_cmd(CMD_CHECK,  32'hFFFF_FFFF);
        queue_cmd(CMD_ADD,    32'h0000_0000);   // sets the flag, table stays empty
        queue_cmd(CMD_REMOVE, 32'h0000_0000);   // clears the flag again
        queue_cmd(CMD_REMOVE, 32'h1234_5678);   // no match on an empty table
        queue_cmd(CMD_NOP,    32'h0000_0000);
        queue_cmd(CMD_ADD,    32'hFFFF_FFFF);
        queue_cmd(CMD_ADD,    32'hFFFF_FFFF);   // adjacent duplicate
        queue_cmd(CMD_ADD,    32'h0000_0001);
        queue_cmd(CMD_ADD,    32'h8000_0000);
        queue_cmd(CMD_ADD,    32'h0000_0001);
        queue_cmd(CMD_ADD,    32'h5555_5555);
        queue_cmd(CMD_ADD,    32'hAAAA_AAAA);
        queue_cmd(CMD_ADD,    32'h0000_0000);   // last slot written with zero
        queue_cmd(CMD_ADD,    32'h7FFF_FFFF);
        queue_cmd(CMD_ADD,    32'h0000_0002);   // table is full
        queue_cmd(CMD_CHECK,  32'h0000_0000);
        queue_cmd(CMD_CHECK,  32'h0000_0001);
        queue_cmd(CMD_NOP,    32'hFFFF_FFFF);
        queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF);   // the neighbor copy survives
        queue_cmd(CMD_CHECK,  32'hFFFF_FFFF);
        queue_cmd(CMD_REMOVE, 32'h0000_0001);
        queue_cmd(CMD_REMOVE, 32'h0000_0000);
        queue_cmd(CMD_REMOVE, 32'h7FFF_FFFF);
        queue_cmd(CMD_CHECK,  32'h0000_0000);
        queue_random_phases();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_queue.size() != 0 || start)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_rsp.size() != 0)
        begin
            failures += expected_rsp.size();
            $display("%0d expected results never arrived.", expected_rsp.size());
        end
        $display("Ran %0d transfers: %0d checks (%0d hits), %0d adds (%0d on a full table),",
                 n_check + n_add + n_remove + n_nop, n_check, n_hit, n_add, n_full);
        $display("%0d removes, %0d unused commands; %0d failures.", n_remove, n_nop, failures);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bpt_pkg.sv
hw/rtl/bpt_ctrl.sv
hw/rtl/bpt_datapath.sv
hw/rtl/breakpoint_address_table.sv
tb/tb_breakpoint_address_table.sv
